/* sv/owm_pkg.sv */
// Shared types and constants for the one-wire bus master.
// Used by owm_cfg_regs and one_wire_bus_master; depends on nothing else.
package owm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_POS_W     = $clog2(BITS_PER_BYTE);
    localparam int TIME_W        = 10;
    localparam int CFG_INDEX_W   = 4;
    localparam int NUM_REGS      = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_WAIT = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_REC     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_LOW     = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_HOLD    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_LOW      = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_SAMPLE   = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_REC      = 4'd7;

    // Reset values, in microsecond ticks
    localparam logic [TIME_W-1:0] RST_RESET_LOW     = 10'd500;
    localparam logic [TIME_W-1:0] RST_PRESENCE_WAIT = 10'd70;
    localparam logic [TIME_W-1:0] RST_RESET_REC     = 10'd500;
    localparam logic [TIME_W-1:0] RST_WRITE_LOW     = 10'd10;
    localparam logic [TIME_W-1:0] RST_WRITE_HOLD    = 10'd50;
    localparam logic [TIME_W-1:0] RST_READ_LOW      = 10'd5;
    localparam logic [TIME_W-1:0] RST_READ_SAMPLE   = 10'd5;
    localparam logic [TIME_W-1:0] RST_READ_REC      = 10'd50;

    // Command opcodes
    localparam logic [1:0] OP_RESET = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] reset_low_time;
        logic [TIME_W-1:0] presence_wait_time;
        logic [TIME_W-1:0] reset_recovery_time;
        logic [TIME_W-1:0] write_low_time;
        logic [TIME_W-1:0] write_hold_time;
        logic [TIME_W-1:0] read_low_time;
        logic [TIME_W-1:0] read_sample_time;
        logic [TIME_W-1:0] read_recovery_time;
    } timing_t;

    typedef struct packed {
        logic       command_valid;
        logic [1:0] opcode;
        logic [7:0] send_byte;
        logic       line_level;
        logic       us_tick;
    } cmd_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence_level;
        logic [7:0] received_byte;
    } res_t;

    typedef enum logic [9:0] {
        PH_IDLE     = 10'b00_0000_0001,
        PH_RST_LOW  = 10'b00_0000_0010,
        PH_RST_WAIT = 10'b00_0000_0100,
        PH_RST_REC  = 10'b00_0000_1000,
        PH_WR_LOW   = 10'b00_0001_0000,
        PH_WR_HOLD  = 10'b00_0010_0000,
        PH_WR_REL   = 10'b00_0100_0000,
        PH_RD_LOW   = 10'b00_1000_0000,
        PH_RD_WAIT  = 10'b01_0000_0000,
        PH_RD_REC   = 10'b10_0000_0000
    } phase_t;

endpackage

/* sv/owm_cfg_regs.sv */
// Timing register file of the one-wire bus master.
// Depends on owm_pkg for the register indexes, reset values and timing_t.
module owm_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [owm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [owm_pkg::TIME_W-1:0]         cfg_data,
    output owm_pkg::timing_t                   timing
);

    owm_pkg::timing_t timing_reg;
    owm_pkg::timing_t timing_next;

    assign cfg_ready = 1'b1;
    assign timing    = timing_reg;

    always_comb
    begin
        timing_next = timing_reg;
        if (cfg_valid)
        begin
            // indexes past the last register are dropped
            unique case (cfg_index)
                owm_pkg::REG_RESET_LOW:     timing_next.reset_low_time      = cfg_data;
                owm_pkg::REG_PRESENCE_WAIT: timing_next.presence_wait_time  = cfg_data;
                owm_pkg::REG_RESET_REC:     timing_next.reset_recovery_time = cfg_data;
                owm_pkg::REG_WRITE_LOW:     timing_next.write_low_time      = cfg_data;
                owm_pkg::REG_WRITE_HOLD:    timing_next.write_hold_time     = cfg_data;
                owm_pkg::REG_READ_LOW:      timing_next.read_low_time       = cfg_data;
                owm_pkg::REG_READ_SAMPLE:   timing_next.read_sample_time    = cfg_data;
                owm_pkg::REG_READ_REC:      timing_next.read_recovery_time  = cfg_data;
                default:                    timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.reset_low_time      <= owm_pkg::RST_RESET_LOW;
            timing_reg.presence_wait_time  <= owm_pkg::RST_PRESENCE_WAIT;
            timing_reg.reset_recovery_time <= owm_pkg::RST_RESET_REC;
            timing_reg.write_low_time      <= owm_pkg::RST_WRITE_LOW;
            timing_reg.write_hold_time     <= owm_pkg::RST_WRITE_HOLD;
            timing_reg.read_low_time       <= owm_pkg::RST_READ_LOW;
            timing_reg.read_sample_time    <= owm_pkg::RST_READ_SAMPLE;
            timing_reg.read_recovery_time  <= owm_pkg::RST_READ_REC;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

endmodule

/* sv/one_wire_bus_master.sv */
// Top level of the one-wire bus master: phase sequencer, slot timer and result register.
// Depends on owm_pkg and owm_cfg_regs.
//
// Each request on cmd is one clock cycle of bus activity: it carries the command offer,
// the sampled line level and the microsecond tick for that cycle. The block takes one
// request per clock while res_ready keeps up and returns exactly one result per request,
// registered, so it shows on res in the cycle after its request; cmd_ready stays high unless
// a result on res is still unread. All bus timing is counted in us_tick pulses against the
// eight timing registers on the cfg port (index 0 to 7, written any time, always ready; a
// value of 0 behaves as 1). A reset command samples presence at the end of the wait phase;
// a read command samples one bit per slot, LSB first, and the byte appears on received_byte
// when the command finishes. Commands offered while busy, and opcode 3, are ignored.
module one_wire_bus_master (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  owm_pkg::cmd_t                   cmd,
    output logic                            res_valid,
    input  logic                            res_ready,
    output owm_pkg::res_t                   res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [owm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [owm_pkg::TIME_W-1:0]      cfg_data
);

    localparam int TW = owm_pkg::TIME_W;
    localparam int BW = owm_pkg::BIT_POS_W;
    localparam logic [BW-1:0] LAST_BIT = BW'(owm_pkg::BITS_PER_BYTE - 1);

    owm_pkg::timing_t timing;

    owm_pkg::phase_t  phase_reg, phase_next;
    logic [TW-1:0]    tick_cnt_reg, tick_cnt_next;
    logic [BW-1:0]    bit_pos_reg, bit_pos_next;
    logic [7:0]       tx_shift_reg, tx_shift_next;
    logic [7:0]       rx_shift_reg, rx_shift_next;
    logic             presence_reg, presence_next;
    logic [7:0]       rd_result_reg, rd_result_next;
    owm_pkg::res_t    res_reg, res_next;
    logic             res_valid_reg;

    logic [TW-1:0]    duration;
    logic             timed;
    logic             expired;
    logic [TW:0]      cnt_plus;
    logic             done;
    logic             accept;

    owm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    assign cmd_ready = !res_valid_reg || res_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // duration of the current timed phase
    always_comb
    begin
        timed    = 1'b1;
        duration = timing.reset_low_time;
        unique case (phase_reg)
            owm_pkg::PH_RST_LOW:  duration = timing.reset_low_time;
            owm_pkg::PH_RST_WAIT: duration = timing.presence_wait_time;
            owm_pkg::PH_RST_REC:  duration = timing.reset_recovery_time;
            owm_pkg::PH_WR_LOW:   duration = timing.write_low_time;
            owm_pkg::PH_WR_HOLD:  duration = timing.write_hold_time;
            owm_pkg::PH_RD_LOW:   duration = timing.read_low_time;
            owm_pkg::PH_RD_WAIT:  duration = timing.read_sample_time;
            owm_pkg::PH_RD_REC:   duration = timing.read_recovery_time;
            default:              timed = 1'b0;
        endcase
    end

    assign cnt_plus = {1'b0, tick_cnt_reg} + {{TW{1'b0}}, 1'b1};
    assign expired  = timed && cmd.us_tick && (cnt_plus >= {1'b0, duration});

    always_comb
    begin
        phase_next     = phase_reg;
        tick_cnt_next  = tick_cnt_reg;
        bit_pos_next   = bit_pos_reg;
        tx_shift_next  = tx_shift_reg;
        rx_shift_next  = rx_shift_reg;
        presence_next  = presence_reg;
        rd_result_next = rd_result_reg;
        done           = 1'b0;

        if (timed && cmd.us_tick)
            tick_cnt_next = expired ? '0 : cnt_plus[TW-1:0];

        unique case (phase_reg)
            owm_pkg::PH_IDLE:
            begin
                if (cmd.command_valid && (cmd.opcode == owm_pkg::OP_RESET ||
                    cmd.opcode == owm_pkg::OP_WRITE || cmd.opcode == owm_pkg::OP_READ))
                begin
                    tick_cnt_next = '0;
                    bit_pos_next  = '0;
                    if (cmd.opcode == owm_pkg::OP_RESET)
                        phase_next = owm_pkg::PH_RST_LOW;
                    else if (cmd.opcode == owm_pkg::OP_WRITE)
                    begin
                        tx_shift_next = cmd.send_byte;
                        phase_next    = owm_pkg::PH_WR_LOW;
                    end
                    else
                    begin
                        rx_shift_next = '0;
                        phase_next    = owm_pkg::PH_RD_LOW;
                    end
                end
            end
            owm_pkg::PH_RST_LOW:
                if (expired) phase_next = owm_pkg::PH_RST_WAIT;
            owm_pkg::PH_RST_WAIT:
                if (expired)
                begin
                    presence_next = cmd.line_level;
                    phase_next    = owm_pkg::PH_RST_REC;
                end
            owm_pkg::PH_RST_REC:
                if (expired)
                begin
                    phase_next = owm_pkg::PH_IDLE;
                    done       = 1'b1;
                end
            owm_pkg::PH_WR_LOW:
                if (expired) phase_next = owm_pkg::PH_WR_HOLD;
            owm_pkg::PH_WR_HOLD:
                if (expired) phase_next = owm_pkg::PH_WR_REL;
            owm_pkg::PH_WR_REL:
            begin
                // release phase after each write slot, before the next slot or the end of the command
                if (bit_pos_reg == LAST_BIT)
                begin
                    phase_next = owm_pkg::PH_IDLE;
                    done       = 1'b1;
                end
                else
                begin
                    bit_pos_next = bit_pos_reg + 1'b1;
                    phase_next   = owm_pkg::PH_WR_LOW;
                end
            end
            owm_pkg::PH_RD_LOW:
                if (expired) phase_next = owm_pkg::PH_RD_WAIT;
            owm_pkg::PH_RD_WAIT:
                if (expired)
                begin
                    rx_shift_next[bit_pos_reg] = rx_shift_reg[bit_pos_reg] | cmd.line_level;
                    phase_next = owm_pkg::PH_RD_REC;
                end
            owm_pkg::PH_RD_REC:
                if (expired)
                begin
                    if (bit_pos_reg == LAST_BIT)
                    begin
                        rd_result_next = rx_shift_reg;
                        phase_next     = owm_pkg::PH_IDLE;
                        done           = 1'b1;
                    end
                    else
                    begin
                        bit_pos_next = bit_pos_reg + 1'b1;
                        phase_next   = owm_pkg::PH_RD_LOW;
                    end
                end
            default:
                phase_next = owm_pkg::PH_IDLE;
        endcase
    end

    // result reflects the state after this cycle's update
    always_comb
    begin
        res_next                = '0;
        res_next.busy_res       = (phase_next != owm_pkg::PH_IDLE);
        res_next.done_res       = done;
        res_next.presence_level = presence_next;
        res_next.received_byte  = rd_result_next;
        case (phase_next) inside
            owm_pkg::PH_RST_LOW, owm_pkg::PH_WR_LOW, owm_pkg::PH_RD_LOW:
                res_next.drive_low = 1'b1;
            owm_pkg::PH_WR_HOLD:
                res_next.drive_low = ~tx_shift_next[bit_pos_next];
            default:
                res_next.drive_low = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= owm_pkg::PH_IDLE;
            tick_cnt_reg  <= '0;
            bit_pos_reg   <= '0;
            tx_shift_reg  <= '0;
            rx_shift_reg  <= '0;
            presence_reg  <= 1'b1;
            rd_result_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                tick_cnt_reg  <= tick_cnt_next;
                bit_pos_reg   <= bit_pos_next;
                tx_shift_reg  <= tx_shift_next;
                rx_shift_reg  <= rx_shift_next;
                presence_reg  <= presence_next;
                rd_result_reg <= rd_result_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

endmodule
